// ===== src/linear_array_queue_assert.svh =====
// assertion macros shared by the linear array queue rtl
// no dependencies; each macro expands to one concurrent assertion
`ifndef LINEAR_ARRAY_QUEUE_ASSERT_SVH
`define LINEAR_ARRAY_QUEUE_ASSERT_SVH

// same-cycle implication
`define LAQ_ASSERT_IMP(name, clock, reset, ante, cons) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("laq assertion failed");

// next-cycle implication
`define LAQ_ASSERT_NXT(name, clock, reset, ante, cons) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("laq assertion failed");

`endif

// ===== src/laq_pkg.sv =====
// shared types and codes for the linear array queue
// no dependencies
`default_nettype none

package laq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 8;
  localparam int unsigned ACT_W  = 3;

  typedef enum logic [2:0] {
    ACT_ENQ   = 3'd0,
    ACT_DEQ   = 3'd1,
    ACT_PEEK  = 3'd2,
    ACT_FIRST = 3'd3,
    ACT_LAST  = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_NOPOS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MEM_NONE = 2'd0,
    MEM_WR   = 2'd1,
    MEM_RD   = 2'd2
  } mem_op_t;

  // per-item command handed from front to back
  typedef struct packed {
    mem_op_t op;
    status_t status;
    logic    is_empty;
    logic    is_full;
  } ctl_t;

endpackage

`default_nettype wire

// ===== src/laq_front.sv =====
// front end: accepts items, checks them against head/tail counters,
// and issues one memory command per item; uses laq_pkg
`default_nettype none

module laq_front #(
  parameter int unsigned DEPTH = 128
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [laq_pkg::ACT_W-1:0]    action,
  input  wire  [laq_pkg::DATA_W-1:0]   value,
  input  wire  [laq_pkg::POS_W-1:0]    position,
  input  wire                          q_ready,
  output logic                         push,
  output laq_pkg::ctl_t                ctl,
  output logic [$clog2(DEPTH)-1:0]     addr,
  output logic [laq_pkg::DATA_W-1:0]   wdata
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > laq_pkg::POS_W) ? CW : laq_pkg::POS_W;

  logic [CW-1:0]   head;
  logic [CW-1:0]   head_next;
  logic [CW-1:0]   tail;
  logic [CW-1:0]   tail_next;
  logic [CW-1:0]   count;
  logic [CW-1:0]   tail_m1;
  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] cnt_ext;
  logic [CMPW-1:0] idx;
  logic            empty;
  logic            full;

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready;
  assign wdata    = value;

  assign empty   = (head == tail);
  assign full    = (tail == CW'(DEPTH));
  assign count   = tail - head;
  assign tail_m1 = tail - CW'(1);
  assign pos_ext = CMPW'(position);
  assign cnt_ext = CMPW'(count);
  assign idx     = CMPW'(head) + pos_ext - CMPW'(1);

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    ctl.op     = laq_pkg::MEM_NONE;
    ctl.status = laq_pkg::ST_OK;
    addr       = '0;
    unique case (action)
      laq_pkg::ACT_ENQ: begin
        if (full) begin
          ctl.status = laq_pkg::ST_FULL;
        end else begin
          ctl.op    = laq_pkg::MEM_WR;
          addr      = tail[AW-1:0];
          tail_next = tail + CW'(1);
        end
      end
      laq_pkg::ACT_DEQ: begin
        if (empty) begin
          ctl.status = laq_pkg::ST_EMPTY;
        end else begin
          ctl.op    = laq_pkg::MEM_RD;
          addr      = head[AW-1:0];
          head_next = head + CW'(1);
        end
      end
      laq_pkg::ACT_PEEK: begin
        if (empty) begin
          ctl.status = laq_pkg::ST_EMPTY;
        end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
          ctl.status = laq_pkg::ST_NOPOS;
        end else begin
          ctl.op = laq_pkg::MEM_RD;
          addr   = idx[AW-1:0];
        end
      end
      laq_pkg::ACT_FIRST: begin
        if (empty) begin
          ctl.status = laq_pkg::ST_EMPTY;
        end else begin
          ctl.op = laq_pkg::MEM_RD;
          addr   = head[AW-1:0];
        end
      end
      laq_pkg::ACT_LAST: begin
        if (empty) begin
          ctl.status = laq_pkg::ST_EMPTY;
        end else begin
          ctl.op = laq_pkg::MEM_RD;
          addr   = tail_m1[AW-1:0];
        end
      end
      default: begin
        // unused codes leave the state alone
      end
    endcase
    ctl.is_empty = (head_next == tail_next);
    ctl.is_full  = (tail_next == CW'(DEPTH));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else if (push) begin
      head <= head_next;
      tail <= tail_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/laq_fifo.sv =====
// two-entry command queue between the front and back ends
// generic payload width; no package dependency
`default_nettype none

module laq_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  output logic             ready,
  input  wire  [WIDTH-1:0] wr_data,
  output logic             valid,
  input  wire              pop,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       level;

  assign ready   = (level != 2'd2);
  assign valid   = (level != 2'd0);
  assign rd_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        level <= level + 2'd1;
      end else if (pop && !push) begin
        level <= level - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/laq_back.sv =====
// back end: owns the slot memory, carries out write/read commands
// and holds the result in an output register; uses laq_pkg
`default_nettype none

module laq_back #(
  parameter int unsigned DEPTH = 128
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cmd_valid,
  output logic                         cmd_pop,
  input  laq_pkg::ctl_t                cmd_ctl,
  input  wire  [$clog2(DEPTH)-1:0]     cmd_addr,
  input  wire  [laq_pkg::DATA_W-1:0]   cmd_wdata,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [laq_pkg::DATA_W-1:0]   out_data,
  output laq_pkg::status_t             out_status,
  output logic                         out_empty,
  output logic                         out_full
);

  logic [laq_pkg::DATA_W-1:0] mem [DEPTH];
  logic [laq_pkg::DATA_W-1:0] rd_data;
  laq_pkg::ctl_t              s1_ctl;
  logic                       s1_valid;
  logic                       s1_move;

  assign s1_move = s1_valid && (!out_valid || out_ready);
  assign cmd_pop = cmd_valid && (!s1_valid || s1_move);

  // one access per command, so write and read never share a cycle
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      if (cmd_ctl.op == laq_pkg::MEM_WR) begin
        mem[cmd_addr] <= cmd_wdata;
      end
      if (cmd_ctl.op == laq_pkg::MEM_RD) begin
        rd_data <= mem[cmd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      s1_ctl <= cmd_ctl;
    end
    if (s1_move) begin
      out_data   <= (s1_ctl.op == laq_pkg::MEM_RD) ? rd_data : '1;
      out_status <= s1_ctl.status;
      out_empty  <= s1_ctl.is_empty;
      out_full   <= s1_ctl.is_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd_pop) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/linear_array_queue.sv =====
// Linear array queue: a non-circular queue of DEPTH 32-bit slots that is
// filled from slot 0 upward and never reuses a slot, so it reports full once
// DEPTH values have been enqueued, even after dequeues. Each input item is one
// action (enqueue, dequeue, peek at a position from the front, first, last)
// and gives exactly one result item with data, a status code and the
// empty/full flags after the action. Errors return data of all ones. The block
// takes one item per cycle while the output is not stalled: an accepted item
// updates the head/tail counters in the front end, which writes the checked
// command into the two-entry command queue; the back end then does the
// registered access of the single-port slot memory and loads the output
// register, where the result waits until taken. With the output stalled the
// block holds four items (output register, memory stage and two queue
// entries) before it stops accepting. No clearing pass is needed after reset.
`default_nettype none

module linear_array_queue #(
  parameter int unsigned DEPTH = 128
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [39:0] s_tdata,   // value[31:0], position[39:32]
  input  wire  [2:0]  s_tuser,   // action[2:0]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata,   // data[31:0]
  output logic [3:0]  m_tuser    // status[1:0], is_empty[2], is_full[3]
);

`include "linear_array_queue_assert.svh"

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned FW = $bits(laq_pkg::ctl_t) + AW + laq_pkg::DATA_W;

  logic                       q_ready;
  logic                       push;
  laq_pkg::ctl_t              push_ctl;
  logic [AW-1:0]              push_addr;
  logic [laq_pkg::DATA_W-1:0] push_wdata;
  logic                       q_valid;
  logic                       q_pop;
  logic [FW-1:0]              q_rd;
  laq_pkg::ctl_t              cmd_ctl;
  logic [AW-1:0]              cmd_addr;
  logic [laq_pkg::DATA_W-1:0] cmd_wdata;
  laq_pkg::status_t           out_status;
  logic                       out_empty;
  logic                       out_full;

  laq_front #(.DEPTH(DEPTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .action   (s_tuser),
    .value    (s_tdata[31:0]),
    .position (s_tdata[39:32]),
    .q_ready  (q_ready),
    .push     (push),
    .ctl      (push_ctl),
    .addr     (push_addr),
    .wdata    (push_wdata)
  );

  laq_fifo #(.WIDTH(FW)) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .ready   (q_ready),
    .wr_data ({push_ctl, push_addr, push_wdata}),
    .valid   (q_valid),
    .pop     (q_pop),
    .rd_data (q_rd)
  );

  assign {cmd_ctl, cmd_addr, cmd_wdata} = q_rd;

  laq_back #(.DEPTH(DEPTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (q_valid),
    .cmd_pop    (q_pop),
    .cmd_ctl    (cmd_ctl),
    .cmd_addr   (cmd_addr),
    .cmd_wdata  (cmd_wdata),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata),
    .out_status (out_status),
    .out_empty  (out_empty),
    .out_full   (out_full)
  );

  assign m_tuser = {out_full, out_empty, out_status};

  // a store only happens on a successful enqueue
  `LAQ_ASSERT_IMP(a_wr_ok, clk, rst, push && push_ctl.op == laq_pkg::MEM_WR, push_ctl.status == laq_pkg::ST_OK)
  // an error never touches the memory
  `LAQ_ASSERT_IMP(a_err_noop, clk, rst, push && push_ctl.status != laq_pkg::ST_OK, push_ctl.op == laq_pkg::MEM_NONE)
  // a queued command stays until the back end takes it
  `LAQ_ASSERT_NXT(a_cmd_kept, clk, rst, q_valid && !q_pop, q_valid)
  // error results carry the all-ones word
  `LAQ_ASSERT_IMP(a_err_word, clk, rst, m_tvalid && m_tuser[1:0] != laq_pkg::ST_OK, m_tdata == '1)

endmodule

`default_nettype wire

// ===== tb/sv/linear_array_queue_test.sv =====
// self-checking testbench for linear_array_queue: directed and random actions on the
// stream ports, checked against an in-bench queue predictor; uses laq_pkg and the rtl only
`timescale 1ns / 1ps

module linear_array_queue_test;

  localparam int unsigned QUEUE_DEPTH    = 128;
  localparam int unsigned HOLDOFF_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_TAIL     = 16;
  localparam logic [31:0] ERR_WORD       = 32'hffff_ffff;
  // action codes the block ignores
  localparam logic [2:0]  ACT_SPARE_LO   = 3'd5;
  localparam logic [2:0]  ACT_SPARE_MID  = 3'd6;
  localparam logic [2:0]  ACT_SPARE_HI   = 3'd7;

  typedef struct packed {
    logic [31:0]      data;
    laq_pkg::status_t status;
    logic             is_empty;
    logic             is_full;
  } queue_result_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;   // value[31:0], position[39:32]
  logic [2:0]  s_tuser  = '0;   // action[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // data[31:0]
  logic [3:0]  m_tuser;         // status[1:0], is_empty[2], is_full[3]

  // predictor state
  logic [31:0]   slot_mem [QUEUE_DEPTH];
  int unsigned   head_cnt = 0;
  int unsigned   tail_cnt = 0;
  queue_result_t pending_results [$];

  // sender pacing
  bit          sender_idle   = 1'b1;
  bit          valid_dropped = 1'b1;
  int unsigned burst_left    = 0;
  int unsigned gap_max       = 6;

  // receiver pacing
  int unsigned holdoff_left = 0;
  int unsigned rx_mode      = 0;
  int unsigned rx_mode_left = 0;

  int unsigned fail_count    = 0;
  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned peak_occupied = 0;
  int unsigned status_hits [4] = '{default: 0};
  int unsigned stall_cycles  = 0;
  queue_result_t want;

  linear_array_queue #(.DEPTH(QUEUE_DEPTH)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic queue_result_t predict_action(logic [2:0] act, logic [31:0] val,
                                                   logic [7:0] pos);
    queue_result_t res;
    int unsigned   occupied;
    bit            empty;
    res.data   = ERR_WORD;
    res.status = laq_pkg::ST_OK;
    occupied   = tail_cnt - head_cnt;
    empty      = (occupied == 0);
    case (act)
      laq_pkg::ACT_ENQ: begin
        if (tail_cnt >= QUEUE_DEPTH) begin
          res.status = laq_pkg::ST_FULL;
        end else begin
          slot_mem[tail_cnt] = val;
          tail_cnt++;
        end
      end
      laq_pkg::ACT_DEQ: begin
        if (empty) begin
          res.status = laq_pkg::ST_EMPTY;
        end else begin
          res.data = slot_mem[head_cnt];
          head_cnt++;
        end
      end
      laq_pkg::ACT_PEEK: begin
        if (empty) begin
          res.status = laq_pkg::ST_EMPTY;
        end else if (pos < 1 || pos > occupied) begin
          res.status = laq_pkg::ST_NOPOS;
        end else begin
          res.data = slot_mem[head_cnt + pos - 1];
        end
      end
      laq_pkg::ACT_FIRST: begin
        if (empty) res.status = laq_pkg::ST_EMPTY;
        else res.data = slot_mem[head_cnt];
      end
      laq_pkg::ACT_LAST: begin
        if (empty) res.status = laq_pkg::ST_EMPTY;
        else res.data = slot_mem[tail_cnt - 1];
      end
      default: ;
    endcase
    res.is_empty = (head_cnt == tail_cnt);
    res.is_full  = (tail_cnt == QUEUE_DEPTH);
    status_hits[res.status]++;
    if (tail_cnt - head_cnt > peak_occupied) peak_occupied = tail_cnt - head_cnt;
    return res;
  endfunction

  // one item: hold it until accepted, predict it, then maybe leave a gap
  task automatic send_item(logic [2:0] act, logic [31:0] val, logic [7:0] pos);
    s_tvalid      <= 1'b1;
    s_tdata       <= {pos, val};
    s_tuser       <= act;
    valid_dropped = 1'b0;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    pending_results.push_back(predict_action(act, val, pos));
    if (sender_idle && burst_left == 0) begin
      s_tvalid      <= 1'b0;
      valid_dropped = 1'b1;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  task automatic wait_all_results();
    if (!valid_dropped) s_tvalid <= 1'b0;
    valid_dropped = 1'b1;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // mostly valid positions, the rest anywhere in the 8-bit range
  function automatic logic [7:0] pick_position();
    int unsigned occupied;
    occupied = tail_cnt - head_cnt;
    if (occupied != 0 && $urandom_range(0, 9) < 8) return 8'($urandom_range(1, occupied));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [2:0] pick_action(int unsigned enq_w, int unsigned deq_w);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < enq_w) return laq_pkg::ACT_ENQ;
    if (r < enq_w + deq_w) return laq_pkg::ACT_DEQ;
    if (r < enq_w + deq_w + 3) return ACT_SPARE_LO + 3'($urandom_range(0, 2));
    case ($urandom_range(0, 3))
      0, 1: return laq_pkg::ACT_PEEK;
      2: return laq_pkg::ACT_FIRST;
      default: return laq_pkg::ACT_LAST;
    endcase
  endfunction

  task automatic send_random(int unsigned enq_w, int unsigned deq_w);
    send_item(pick_action(enq_w, deq_w), $urandom, pick_position());
  endtask

  task automatic test_empty_queue();
    send_item(laq_pkg::ACT_DEQ, $urandom, 8'd1);
    send_item(laq_pkg::ACT_PEEK, $urandom, 8'd1);
    send_item(laq_pkg::ACT_PEEK, $urandom, 8'd0);
    send_item(laq_pkg::ACT_FIRST, $urandom, 8'd0);
    send_item(laq_pkg::ACT_LAST, $urandom, 8'd255);
    send_item(ACT_SPARE_LO, 32'h7fff_ffff, 8'd3);
    send_item(ACT_SPARE_MID, 32'h8000_0000, 8'd128);
    send_item(ACT_SPARE_HI, 32'hffff_ffff, 8'd255);
  endtask

  task automatic test_edge_values();
    send_item(laq_pkg::ACT_ENQ, 32'h7fff_ffff, 8'd0);
    send_item(laq_pkg::ACT_ENQ, 32'h8000_0000, 8'd255);
    send_item(laq_pkg::ACT_ENQ, 32'h0000_0000, 8'd1);
    send_item(laq_pkg::ACT_ENQ, 32'hffff_ffff, 8'd128);
    send_item(laq_pkg::ACT_ENQ, 32'ha5a5_5a5a, 8'd7);
    send_item(laq_pkg::ACT_PEEK, $urandom, 8'd0);
    send_item(laq_pkg::ACT_PEEK, $urandom, 8'd1);
    send_item(laq_pkg::ACT_PEEK, $urandom, 8'd5);
    send_item(laq_pkg::ACT_PEEK, $urandom, 8'd6);
    send_item(laq_pkg::ACT_PEEK, $urandom, 8'd255);
    send_item(laq_pkg::ACT_PEEK, $urandom, 8'd128);
    send_item(laq_pkg::ACT_FIRST, $urandom, 8'd0);
    send_item(laq_pkg::ACT_LAST, $urandom, 8'd0);
    send_item(laq_pkg::ACT_DEQ, $urandom, 8'd0);
  endtask

  // enqueue and dequeue rates vary so the queue grows, drains and grows again;
  // the enqueue budget is kept well under the slot count
  task automatic test_random_traffic();
    repeat (200) send_random(12, 4);
    repeat (200) send_random(6, 12);
    sender_idle = 1'b0;
    repeat (200) send_random(12, 6);
    sender_idle = 1'b1;
    repeat (200) send_random(8, 8);
  endtask

  // drain first, then block the output long enough that the input stalls
  task automatic test_backpressure();
    wait_all_results();
    holdoff_left <= HOLDOFF_CYCLES;
    sender_idle = 1'b0;
    repeat (40) send_random(15, 5);
    sender_idle = 1'b1;
  endtask

  task automatic test_fill_and_drain();
    int unsigned occupied;
    while (tail_cnt < QUEUE_DEPTH) begin
      if ($urandom_range(0, 3) == 0) send_random(0, 0);
      else send_item(laq_pkg::ACT_ENQ, pick_value(), pick_position());
    end
    repeat (4) send_item(laq_pkg::ACT_ENQ, pick_value(), pick_position());
    occupied = tail_cnt - head_cnt;
    send_item(laq_pkg::ACT_PEEK, $urandom, 8'(occupied));
    send_item(laq_pkg::ACT_PEEK, $urandom, 8'(occupied + 1));
    while (head_cnt != tail_cnt) begin
      if ($urandom_range(0, 2) == 0) send_random(0, 0);
      else send_item(laq_pkg::ACT_DEQ, $urandom, pick_position());
    end
    // empty and full at once: slots are not reused
    send_item(laq_pkg::ACT_ENQ, 32'h1234_5678, 8'd1);
    send_item(laq_pkg::ACT_PEEK, $urandom, 8'd1);
    send_item(laq_pkg::ACT_FIRST, $urandom, 8'd0);
    send_item(laq_pkg::ACT_LAST, $urandom, 8'd0);
    send_item(laq_pkg::ACT_DEQ, $urandom, 8'd0);
    send_item(ACT_SPARE_HI, $urandom, 8'd0);
    repeat (20) send_random(30, 20);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_empty_queue();
    test_edge_values();
    test_random_traffic();
    test_backpressure();
    test_fill_and_drain();
    wait_all_results();
    repeat (DRAIN_TAIL) @(posedge clk);
    $display("covered %0d items: %0d ok, %0d empty, %0d full, %0d bad position; peak depth %0d",
             items_sent, status_hits[laq_pkg::ST_OK], status_hits[laq_pkg::ST_EMPTY],
             status_hits[laq_pkg::ST_FULL], status_hits[laq_pkg::ST_NOPOS], peak_occupied);
    $display("%0d results checked, %0d mismatches", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // receiver: pattern of its own, plus a counted hold-off on request
  always @(posedge clk) begin
    if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
      m_tready     <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= $urandom_range(0, 3);
        rx_mode_left <= $urandom_range(20, 120);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= ($urandom_range(0, 9) != 0);
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic report_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
    if (exp_val !== got_val) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val, got_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got data %h flags %h",
                 $time, m_tdata, m_tuser);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        report_field("data", want.data, m_tdata);
        report_field("status", 32'(want.status), 32'(m_tuser[1:0]));
        report_field("is_empty", 32'(want.is_empty), 32'(m_tuser[2]));
        report_field("is_full", 32'(want.is_full), 32'(m_tuser[3]));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, stall_cycles, pending_results.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
